/* rtl/uarttp_pkg.sv */
// uarttp_pkg: shared constants and types for the uart transceiver with parity
package uarttp_pkg;

   localparam int TICK_COUNTER_WIDTH = 16;
   localparam int RX_COUNT_WIDTH     = TICK_COUNTER_WIDTH + 1;
   localparam int CSR_ADDR_WIDTH     = 5;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int REQ_DATA_WIDTH     = 16;
   localparam int RSP_DATA_WIDTH     = 16;

   // register indexes
   localparam logic [2:0] REG_BIT_PERIOD      = 3'd0;
   localparam logic [2:0] REG_WORD_LEN        = 3'd1;
   localparam logic [2:0] REG_PARITY_MODE     = 3'd2;
   localparam logic [2:0] REG_TWO_STOP_BITS   = 3'd3;
   localparam logic [2:0] REG_CHECK_START_BIT = 3'd4;
   localparam logic [2:0] REG_CHECK_RX_PARITY = 3'd5;

   // parity modes
   localparam logic [1:0] PAR_NONE = 2'd0;
   localparam logic [1:0] PAR_ODD  = 2'd1;
   localparam logic [1:0] PAR_EVEN = 2'd2;

   // receive phases: data bits follow from RX_DATA0 on, parity after them
   localparam logic [3:0] RX_IDLE  = 4'd0;
   localparam logic [3:0] RX_START = 4'd1;
   localparam logic [3:0] RX_DATA0 = 4'd2;

   // transmit phase is one plus the index of the bit on the line
   localparam logic [3:0] TX_IDLE  = 4'd0;
   localparam logic [3:0] TX_START = 4'd1;

   localparam logic [TICK_COUNTER_WIDTH-1:0] BIT_PERIOD_RESET = 104;
   localparam logic [TICK_COUNTER_WIDTH-1:0] BIT_PERIOD_MIN   = 2;
   localparam logic [3:0] WORD_LEN_RESET = 4'd8;
   localparam logic [3:0] WORD_LEN_MIN   = 4'd5;
   localparam logic [3:0] WORD_LEN_MAX   = 4'd8;

   typedef struct packed {
      logic [TICK_COUNTER_WIDTH-1:0] bit_period;
      logic [3:0]                    word_len;
      logic [1:0]                    parity_mode;
      logic                          two_stop_bits;
      logic                          check_start_bit;
      logic                          check_rx_parity;
   } cfg_type;

   typedef struct packed {
      logic       rx_parity_error;
      logic [7:0] rx_data;
      logic       rx_strobe;
      logic       tx_done;
      logic       tx_busy;
      logic       tx_line;
   } result_type;

endpackage

/* rtl/uart_transceiver_parity_top.sv */
// uart_transceiver_parity_top: uart transmitter and receiver with optional parity
//
// Each req item is one timer tick carrying the sampled receive line and an optional
// byte to send; each accepted item yields exactly one rsp item showing the line
// state after that tick. The transmit and receive state machines and the result
// register are updated in the cycle the item is accepted, and a new item is taken
// every cycle as long as the result register is empty or being drained. Settings
// are to be written through the csr port only while no tick is in flight; the block
// does not enforce this. bit_period is in ticks per bit (values below 2 act as 2), a
// data length below 5 acts as 5 and above 8 as 8, parity mode three acts as no parity.
module uart_transceiver_parity_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // bit 0 rx_line, bit 1 send_start, bits 9:2 send_byte, rest zero
   input  logic [uarttp_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // bit 0 tx_line, 1 tx_busy, 2 tx_done, 3 rx_strobe, 11:4 rx_data,
   // 12 rx_parity_error, rest zero
   output logic [uarttp_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [uarttp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [uarttp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [uarttp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   localparam int TW = uarttp_pkg::TICK_COUNTER_WIDTH;
   localparam int RW = uarttp_pkg::RX_COUNT_WIDTH;

   uarttp_pkg::cfg_type cfg_ff, cfg_in;

   logic          rx_prev_ff, rx_prev_in;
   logic [3:0]    rx_phase_ff, rx_phase_in;
   logic [RW-1:0] rx_count_ff, rx_count_in;
   logic [7:0]    rx_shift_ff, rx_shift_in;
   logic [7:0]    rx_hold_ff, rx_hold_in;
   logic [3:0]    tx_phase_ff, tx_phase_in;
   logic [TW-1:0] tx_count_ff, tx_count_in;
   logic [7:0]    tx_shift_ff, tx_shift_in;
   logic          tx_parity_ff, tx_parity_in;
   logic          tx_level_ff, tx_level_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   uarttp_pkg::result_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          in_line, in_start;
   logic [7:0]    in_byte;
   logic [TW-1:0] period;
   logic [3:0]    nd;
   logic          pbits;
   logic [7:0]    data_mask;
   logic [7:0]    tx_data;
   logic [3:0]    tx_total;
   logic [RW-1:0] rx_count_dec;
   logic [7:0]    rx_shifted;
   logic [3:0]    rx_align;
   logic [7:0]    rx_word;
   logic          rx_ones;
   logic          rx_bad;
   logic          tx_done, rx_strobe, rx_err;
   logic          csr_write;
   logic [2:0]    csr_index;

   assign in_line  = req_tdata[0];
   assign in_start = req_tdata[1];
   assign in_byte  = req_tdata[9:2];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(uarttp_pkg::RSP_DATA_WIDTH - $bits(rsp_data_ff)){1'b0}}, rsp_data_ff};

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            uarttp_pkg::REG_BIT_PERIOD:      cfg_in.bit_period      = csr_pwdata[TW-1:0];
            uarttp_pkg::REG_WORD_LEN:        cfg_in.word_len        = csr_pwdata[3:0];
            uarttp_pkg::REG_PARITY_MODE:     cfg_in.parity_mode     = csr_pwdata[1:0];
            uarttp_pkg::REG_TWO_STOP_BITS:   cfg_in.two_stop_bits   = csr_pwdata[0];
            uarttp_pkg::REG_CHECK_START_BIT: cfg_in.check_start_bit = csr_pwdata[0];
            uarttp_pkg::REG_CHECK_RX_PARITY: cfg_in.check_rx_parity = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         uarttp_pkg::REG_BIT_PERIOD:      csr_prdata[TW-1:0] = cfg_ff.bit_period;
         uarttp_pkg::REG_WORD_LEN:        csr_prdata[3:0]    = cfg_ff.word_len;
         uarttp_pkg::REG_PARITY_MODE:     csr_prdata[1:0]    = cfg_ff.parity_mode;
         uarttp_pkg::REG_TWO_STOP_BITS:   csr_prdata[0]      = cfg_ff.two_stop_bits;
         uarttp_pkg::REG_CHECK_START_BIT: csr_prdata[0]      = cfg_ff.check_start_bit;
         uarttp_pkg::REG_CHECK_RX_PARITY: csr_prdata[0]      = cfg_ff.check_rx_parity;
         default: ;
      endcase
   end

   // effective settings
   always_comb begin
      period = (cfg_ff.bit_period < uarttp_pkg::BIT_PERIOD_MIN) ?
               uarttp_pkg::BIT_PERIOD_MIN : cfg_ff.bit_period;
      if (cfg_ff.word_len < uarttp_pkg::WORD_LEN_MIN) begin
         nd = uarttp_pkg::WORD_LEN_MIN;
      end else if (cfg_ff.word_len > uarttp_pkg::WORD_LEN_MAX) begin
         nd = uarttp_pkg::WORD_LEN_MAX;
      end else begin
         nd = cfg_ff.word_len;
      end
      pbits = (cfg_ff.parity_mode == uarttp_pkg::PAR_ODD) ||
              (cfg_ff.parity_mode == uarttp_pkg::PAR_EVEN);
      data_mask = 8'hff >> (4'd8 - nd);
   end

   // transmit side
   always_comb begin
      tx_phase_in  = tx_phase_ff;
      tx_count_in  = tx_count_ff;
      tx_shift_in  = tx_shift_ff;
      tx_parity_in = tx_parity_ff;
      tx_level_in  = tx_level_ff;
      tx_done      = 1'b0;
      tx_data      = in_byte & data_mask;
      tx_total     = 4'd2 + nd + {3'd0, pbits} + {3'd0, cfg_ff.two_stop_bits};
      if (tx_phase_ff == uarttp_pkg::TX_IDLE) begin
         if (in_start) begin
            tx_shift_in  = tx_data;
            tx_parity_in = (^tx_data) ^ (cfg_ff.parity_mode == uarttp_pkg::PAR_ODD);
            tx_level_in  = 1'b0;
            tx_phase_in  = uarttp_pkg::TX_START;
            tx_count_in  = '0;
         end
      end else if ({1'b0, tx_count_ff} + 1'b1 >= {1'b0, period}) begin
         tx_count_in = '0;
         if (tx_phase_ff >= tx_total) begin
            tx_phase_in = uarttp_pkg::TX_IDLE;
            tx_level_in = 1'b1;
            tx_done     = 1'b1;
         end else begin
            tx_phase_in = tx_phase_ff + 4'd1;
            if (tx_phase_ff <= nd) begin
               tx_level_in = tx_shift_ff[0];
               tx_shift_in = tx_shift_ff >> 1;
            end else if (pbits && tx_phase_ff == nd + 4'd1) begin
               tx_level_in = tx_parity_ff;
            end else begin
               tx_level_in = 1'b1;
            end
         end
      end else begin
         tx_count_in = tx_count_ff + 1'b1;
      end
   end

   // receive side
   always_comb begin
      rx_phase_in  = rx_phase_ff;
      rx_count_in  = rx_count_ff;
      rx_shift_in  = rx_shift_ff;
      rx_hold_in   = rx_hold_ff;
      rx_prev_in   = in_line;
      rx_strobe    = 1'b0;
      rx_err       = 1'b0;
      rx_count_dec = (rx_count_ff != '0) ? rx_count_ff - 1'b1 : rx_count_ff;
      rx_shifted   = {in_line, rx_shift_ff[7:1]};
      rx_align     = 4'd8 - nd;
      rx_word      = rx_shift_ff >> rx_align;
      rx_ones      = (^rx_word) ^ in_line;
      rx_bad       = ((cfg_ff.parity_mode == uarttp_pkg::PAR_ODD) && !rx_ones) ||
                     ((cfg_ff.parity_mode == uarttp_pkg::PAR_EVEN) && rx_ones);
      if (rx_phase_ff == uarttp_pkg::RX_IDLE) begin
         if (rx_prev_ff && !in_line) begin
            rx_shift_in = '0;
            if (cfg_ff.check_start_bit) begin
               rx_phase_in = uarttp_pkg::RX_START;
               rx_count_in = {2'b00, period[TW-1:1]};
            end else begin
               // one and a half bits to the first data bit centre
               rx_phase_in = uarttp_pkg::RX_DATA0;
               rx_count_in = {1'b0, period} + {2'b00, period[TW-1:1]};
            end
         end
      end else begin
         rx_count_in = rx_count_dec;
         if (rx_count_dec == '0) begin
            if (rx_phase_ff == uarttp_pkg::RX_START) begin
               if (in_line) begin
                  rx_phase_in = uarttp_pkg::RX_IDLE;
               end else begin
                  rx_phase_in = uarttp_pkg::RX_DATA0;
                  rx_count_in = {1'b0, period};
               end
            end else if (rx_phase_ff < uarttp_pkg::RX_DATA0 + nd) begin
               rx_shift_in = rx_shifted;
               if ((rx_phase_ff + 4'd1 < uarttp_pkg::RX_DATA0 + nd) || pbits) begin
                  rx_phase_in = rx_phase_ff + 4'd1;
                  rx_count_in = {1'b0, period};
               end else begin
                  rx_hold_in  = rx_shifted >> rx_align;
                  rx_strobe   = 1'b1;
                  rx_phase_in = uarttp_pkg::RX_IDLE;
               end
            end else begin
               if (cfg_ff.check_rx_parity && rx_bad) begin
                  rx_err = 1'b1;
               end else begin
                  rx_hold_in = rx_word;
                  rx_strobe  = 1'b1;
               end
               rx_phase_in = uarttp_pkg::RX_IDLE;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.tx_line         = tx_level_in;
         rsp_data_in.tx_busy         = (tx_phase_in != uarttp_pkg::TX_IDLE);
         rsp_data_in.tx_done         = tx_done;
         rsp_data_in.rx_strobe       = rx_strobe;
         rsp_data_in.rx_data         = rx_hold_in;
         rsp_data_in.rx_parity_error = rx_err;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period      <= uarttp_pkg::BIT_PERIOD_RESET;
         cfg_ff.word_len        <= uarttp_pkg::WORD_LEN_RESET;
         cfg_ff.parity_mode     <= uarttp_pkg::PAR_NONE;
         cfg_ff.two_stop_bits   <= 1'b0;
         cfg_ff.check_start_bit <= 1'b1;
         cfg_ff.check_rx_parity <= 1'b1;
         rx_prev_ff   <= 1'b1;
         rx_phase_ff  <= uarttp_pkg::RX_IDLE;
         rx_count_ff  <= '0;
         rx_shift_ff  <= '0;
         rx_hold_ff   <= '0;
         tx_phase_ff  <= uarttp_pkg::TX_IDLE;
         tx_count_ff  <= '0;
         tx_shift_ff  <= '0;
         tx_parity_ff <= 1'b0;
         tx_level_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            rx_prev_ff   <= rx_prev_in;
            rx_phase_ff  <= rx_phase_in;
            rx_count_ff  <= rx_count_in;
            rx_shift_ff  <= rx_shift_in;
            rx_hold_ff   <= rx_hold_in;
            tx_phase_ff  <= tx_phase_in;
            tx_count_ff  <= tx_count_in;
            tx_shift_ff  <= tx_shift_in;
            tx_parity_ff <= tx_parity_in;
            tx_level_ff  <= tx_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* bench/tb_uart_transceiver_parity_top.sv */
// testbench for the uart transceiver with parity: random ticks checked against a tick model
`timescale 1ns / 1ps

module tb_uart_transceiver_parity_top;

   typedef struct packed {
      logic       rx_in;
      logic       send_req;
      logic [7:0] send_val;
   } tick_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [uarttp_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [uarttp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [uarttp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [uarttp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [uarttp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                  csr_pready;

   uart_transceiver_parity_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // settings as the block sees them
   uarttp_pkg::cfg_type cfg = '{bit_period: uarttp_pkg::BIT_PERIOD_RESET,
                                word_len: uarttp_pkg::WORD_LEN_RESET,
                                parity_mode: uarttp_pkg::PAR_NONE, two_stop_bits: 1'b0,
                                check_start_bit: 1'b1, check_rx_parity: 1'b1};

   // model of the line state
   logic        rx_prev = 1'b1;
   int unsigned rx_ph = 0, rx_cnt = 0, tx_ph = 0, tx_cnt = 0;
   logic [7:0]  rx_sh = '0, rx_hold = '0, tx_sh = '0;
   logic        tx_par = 1'b0, tx_lvl = 1'b1;

   tick_type               ticks_to_send[$];
   uarttp_pkg::result_type line_states_due[$];
   int unsigned ticks_queued = 0, ticks_accepted = 0, settings_used = 0;
   int unsigned send_idle_pct = 0, recv_idle_pct = 0;
   int unsigned error_count = 0, n_received = 0, n_parity_drops = 0, n_frames_sent = 0;
   logic                   req_taken = 1'b0;
   tick_type               cur_tick;
   uarttp_pkg::result_type want, got;

   function automatic int unsigned eff_period();
      return (cfg.bit_period < uarttp_pkg::BIT_PERIOD_MIN) ?
             uarttp_pkg::BIT_PERIOD_MIN : cfg.bit_period;
   endfunction

   function automatic int unsigned eff_bits();
      if (cfg.word_len < uarttp_pkg::WORD_LEN_MIN) return uarttp_pkg::WORD_LEN_MIN;
      if (cfg.word_len > uarttp_pkg::WORD_LEN_MAX) return uarttp_pkg::WORD_LEN_MAX;
      return cfg.word_len;
   endfunction

   function automatic bit parity_active();
      return cfg.parity_mode == uarttp_pkg::PAR_ODD || cfg.parity_mode == uarttp_pkg::PAR_EVEN;
   endfunction

   // advance transmit and receive by one tick, return the line state after it
   function automatic uarttp_pkg::result_type next_line_state(input logic rx_in,
                                                              input logic send_req,
                                                              input logic [7:0] send_val);
      int unsigned per, nd, pbits, idx;
      logic [7:0]  d;
      logic        ones, bad;
      uarttp_pkg::result_type r;
      per   = eff_period();
      nd    = eff_bits();
      pbits = parity_active() ? 1 : 0;
      r     = '0;

      if (tx_ph == uarttp_pkg::TX_IDLE) begin
         if (send_req) begin
            d      = send_val & (8'hFF >> (8 - nd));
            tx_sh  = d;
            tx_par = (cfg.parity_mode == uarttp_pkg::PAR_ODD) ? ~^d : ^d;
            tx_lvl = 1'b0;
            tx_ph  = uarttp_pkg::TX_START;
            tx_cnt = 0;
         end
      end else if (tx_cnt + 1 >= per) begin
         tx_cnt = 0;
         if (tx_ph >= 2 + nd + pbits + cfg.two_stop_bits) begin
            tx_ph     = uarttp_pkg::TX_IDLE;
            tx_lvl    = 1'b1;
            r.tx_done = 1'b1;
         end else begin
            idx   = tx_ph;
            tx_ph = tx_ph + 1;
            if (idx <= nd) begin
               tx_lvl = tx_sh[0];
               tx_sh  = tx_sh >> 1;
            end else if (pbits == 1 && idx == nd + 1) begin
               tx_lvl = tx_par;
            end else begin
               tx_lvl = 1'b1;
            end
         end
      end else begin
         tx_cnt++;
      end

      if (rx_ph == uarttp_pkg::RX_IDLE) begin
         if (rx_prev && !rx_in) begin
            rx_sh = '0;
            if (cfg.check_start_bit) begin
               rx_ph  = uarttp_pkg::RX_START;
               rx_cnt = per / 2;
            end else begin
               rx_ph  = uarttp_pkg::RX_DATA0;
               rx_cnt = (per * 3) / 2;
            end
         end
      end else begin
         if (rx_cnt > 0) rx_cnt--;
         if (rx_cnt == 0) begin
            if (rx_ph == uarttp_pkg::RX_START) begin
               if (rx_in) begin
                  rx_ph = uarttp_pkg::RX_IDLE;
               end else begin
                  rx_ph  = uarttp_pkg::RX_DATA0;
                  rx_cnt = per;
               end
            end else if (rx_ph < uarttp_pkg::RX_DATA0 + nd) begin
               rx_sh = {rx_in, rx_sh[7:1]};
               if (rx_ph + 1 < uarttp_pkg::RX_DATA0 + nd || pbits == 1) begin
                  rx_ph  = rx_ph + 1;
                  rx_cnt = per;
               end else begin
                  rx_hold     = rx_sh >> (8 - nd);
                  r.rx_strobe = 1'b1;
                  rx_ph       = uarttp_pkg::RX_IDLE;
               end
            end else begin
               // parity bit centre, also reached when data bits shrank mid-frame
               d    = rx_sh >> (8 - nd);
               ones = ^d ^ rx_in;
               bad  = (cfg.parity_mode == uarttp_pkg::PAR_ODD && !ones) ||
                      (cfg.parity_mode == uarttp_pkg::PAR_EVEN && ones);
               if (cfg.check_rx_parity && bad) begin
                  r.rx_parity_error = 1'b1;
               end else begin
                  rx_hold     = d;
                  r.rx_strobe = 1'b1;
               end
               rx_ph = uarttp_pkg::RX_IDLE;
            end
         end
      end
      rx_prev = rx_in;

      r.tx_line = tx_lvl;
      r.tx_busy = (tx_ph != uarttp_pkg::TX_IDLE);
      r.rx_data = rx_hold;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned exp_v,
                                  input logic [7:0] act_v);
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, exp_v, act_v);
      error_count++;
   endtask

   // driver: one item per handshake, gaps drawn per cycle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_tick = ticks_to_send.pop_front();
            req_tdata  <= {6'b0, cur_tick.send_val, cur_tick.send_req, cur_tick.rx_in};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: predict on each accepted tick, check each accepted result
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            line_states_due.push_back(next_line_state(req_tdata[0], req_tdata[1],
                                                      req_tdata[9:2]));
            ticks_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = uarttp_pkg::result_type'(rsp_tdata[$bits(uarttp_pkg::result_type)-1:0]);
            if (line_states_due.size() == 0) begin
               $display("%0t: unexpected result, expected none got %0h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = line_states_due.pop_front();
               if (want.tx_line !== got.tx_line)
                  report_mismatch("tx_line", want.tx_line, got.tx_line);
               if (want.tx_busy !== got.tx_busy)
                  report_mismatch("tx_busy", want.tx_busy, got.tx_busy);
               if (want.tx_done !== got.tx_done)
                  report_mismatch("tx_done", want.tx_done, got.tx_done);
               if (want.rx_strobe !== got.rx_strobe)
                  report_mismatch("rx_strobe", want.rx_strobe, got.rx_strobe);
               if (want.rx_data !== got.rx_data)
                  report_mismatch("rx_data", want.rx_data, got.rx_data);
               if (want.rx_parity_error !== got.rx_parity_error)
                  report_mismatch("rx_parity_error", want.rx_parity_error,
                                  got.rx_parity_error);
            end
            n_received     += (got.rx_strobe === 1'b1);
            n_parity_drops += (got.rx_parity_error === 1'b1);
            n_frames_sent  += (got.tx_done === 1'b1);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         uarttp_pkg::REG_BIT_PERIOD:
            cfg.bit_period = value[uarttp_pkg::TICK_COUNTER_WIDTH-1:0];
         uarttp_pkg::REG_WORD_LEN:        cfg.word_len        = value[3:0];
         uarttp_pkg::REG_PARITY_MODE:     cfg.parity_mode     = value[1:0];
         uarttp_pkg::REG_TWO_STOP_BITS:   cfg.two_stop_bits   = value[0];
         uarttp_pkg::REG_CHECK_START_BIT: cfg.check_start_bit = value[0];
         uarttp_pkg::REG_CHECK_RX_PARITY: cfg.check_rx_parity = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] per, input logic [3:0] nd,
                                 input logic [1:0] pm, input logic two_stop,
                                 input logic chk_start, input logic chk_par);
      csr_write(uarttp_pkg::REG_BIT_PERIOD, 32'(per));
      csr_write(uarttp_pkg::REG_WORD_LEN, 32'(nd));
      csr_write(uarttp_pkg::REG_PARITY_MODE, 32'(pm));
      csr_write(uarttp_pkg::REG_TWO_STOP_BITS, 32'(two_stop));
      csr_write(uarttp_pkg::REG_CHECK_START_BIT, 32'(chk_start));
      csr_write(uarttp_pkg::REG_CHECK_RX_PARITY, 32'(chk_par));
      settings_used++;
   endtask

   // hold the sender until every queued tick has come back, then a short pause
   task automatic wait_drained();
      while (ticks_accepted != ticks_queued || line_states_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_item(input logic rx_in, input logic send_req, input logic [7:0] val);
      ticks_to_send.push_back('{rx_in: rx_in, send_req: send_req, send_val: val});
      ticks_queued++;
   endtask

   task automatic push_tick(input logic rx_in);
      push_item(rx_in, $urandom_range(15) == 0, 8'($urandom_range(255)));
   endtask

   // one receive frame at the current settings, cut after keep ticks
   task automatic push_frame(input logic [7:0] data, input bit bad_parity,
                             input int unsigned keep);
      int unsigned per, nd, n;
      logic        frame_bits[$];
      per  = eff_period();
      nd   = eff_bits();
      data = data & (8'hFF >> (8 - nd));
      n    = 0;
      frame_bits.push_back(1'b0);
      for (int i = 0; i < nd; i++) frame_bits.push_back(data[i]);
      if (parity_active())
         frame_bits.push_back(((cfg.parity_mode == uarttp_pkg::PAR_ODD) ? ~^data : ^data)
                              ^ bad_parity);
      frame_bits.push_back(1'b1);
      if (cfg.two_stop_bits) frame_bits.push_back(1'b1);
      foreach (frame_bits[b])
         repeat (per) begin
            if (n < keep) push_tick(frame_bits[b]);
            n++;
         end
   endtask

   initial begin
      int unsigned kind, per;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: send all ones, then all zeros and 5A while busy, so neither is sent
      send_idle_pct = 25;
      recv_idle_pct = 83;
      push_item(1'b1, 1'b1, 8'hFF);
      push_item(1'b1, 1'b1, 8'h00);
      push_item(1'b1, 1'b0, 8'hA5);
      push_item(1'b1, 1'b1, 8'h5A);
      wait_drained();

      // period below minimum, too few data bits, parity mode three, mid-frame change
      apply_settings(16'd0, 4'd4, 2'd3, 1'b1, 1'b0, 1'b0);
      push_frame(8'h16, 1'b0, 32'hFFFF_FFFF);
      push_item(1'b1, 1'b1, 8'h00);
      push_item(1'b1, 1'b1, 8'hFF);
      wait_drained();

      // largest period: line stays high, transmitter just starts
      apply_settings(16'hFFFF, 4'd15, uarttp_pkg::PAR_EVEN, 1'b0, 1'b1, 1'b1);
      repeat (12) push_item(1'b1, 1'b1, 8'($urandom_range(255)));
      wait_drained();

      while (ticks_queued < 680) begin
         if (ticks_queued < 270) begin
            send_idle_pct = 25;
            recv_idle_pct = 83;
         end else if (ticks_queued < 530) begin
            send_idle_pct = 83;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_settings(16'(($urandom_range(9) == 0) ? $urandom_range(1)
                                                     : $urandom_range(2, 6)),
                        4'(($urandom_range(4) == 0) ? $urandom_range(15)
                                                    : $urandom_range(5, 8)),
                        2'($urandom_range(3)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
         per = eff_period();
         repeat ($urandom_range(3, 6)) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
               push_frame(8'($urandom_range(255)),
                          parity_active() && $urandom_range(3) == 0, 32'hFFFF_FFFF);
            end else if (kind < 75) begin
               // low pulse too short to survive the start bit check
               repeat ($urandom_range(1, per / 2)) push_tick(1'b0);
            end else if (kind < 85) begin
               repeat ($urandom_range(1, 8)) push_tick(1'($urandom_range(1)));
            end else begin
               push_frame(8'($urandom_range(255)), 1'b0, $urandom_range(1, per * 6));
            end
            repeat ($urandom_range(0, 2 * per)) push_tick(1'b1);
         end
         // phase ends wherever the frames stand, so settings change mid-frame
         wait_drained();
      end

      repeat (8) @(negedge clock);
      $display("ran %0d ticks under %0d settings with varied handshake gaps",
               ticks_accepted, settings_used);
      $display("saw %0d bytes received, %0d parity drops, %0d frames sent",
               n_received, n_parity_drops, n_frames_sent);
      if (error_count == 0 && line_states_due.size() == 0) begin
         $display("[uart_transceiver_parity_top] OK");
      end else begin
         $display("[uart_transceiver_parity_top] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", line_states_due.size());
      $display("[uart_transceiver_parity_top] ERROR");
      $finish;
   end

endmodule
